// ===== design/rpb_pkg.sv =====
// rpb_pkg: shared constants, types and fixed-point log2 helpers for the
// relative position bucket block. No dependencies.
`default_nettype none

package rpb_pkg;

  localparam int POS_BITS      = 16;
  localparam int LOG_FRAC_BITS = 16;

  localparam int BC_W       = 9;
  localparam int FAR_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int BUCKET_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_DISTANCE = 1'b1;

  localparam logic [BC_W-1:0]  BC_RESET  = 9'd32;
  localparam logic [FAR_W-1:0] FAR_RESET = 16'd128;
  localparam logic [BC_W-1:0]  BC_MAX    = 9'd256;

  localparam int NORM_W  = (POS_BITS > FAR_W) ? POS_BITS : FAR_W;
  localparam int KW      = $clog2(NORM_W);
  localparam int LOG_W   = KW + LOG_FRAC_BITS;
  localparam int MANT_W  = 32;
  localparam int PROD_W  = 2 * MANT_W;
  localparam int HALF_W  = 8;
  localparam int EXACT_W = HALF_W - 1;
  localparam int QW      = EXACT_W;
  localparam int DV_W    = LOG_W + QW;
  localparam int CNT_W   = $clog2(LOG_FRAC_BITS);

  localparam int DIV_STAGES = QW + 4;

  typedef struct packed {
    logic [KW-1:0]     k;
    logic [MANT_W-1:0] mant;
  } norm_t;

  typedef struct packed {
    logic              hit;
    logic [MANT_W-1:0] mant;
  } sq_t;

  typedef struct packed {
    logic [HALF_W-1:0]  half;
    logic [EXACT_W-1:0] exact;
    logic [EXACT_W-1:0] span;
    logic [LOG_W-1:0]   l_exact;
    logic [LOG_W-1:0]   den;
    logic               degen;
  } cfg_t;

  typedef struct packed {
    logic                direct;
    logic [BUCKET_W-1:0] bucket;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic [MANT_W-1:0] mant;
    logic [LOG_W-1:0]  acc;
  } log_item_t;

  typedef struct packed {
    tag_t            tag;
    logic [DV_W-1:0] val;
    logic [QW-1:0]   q;
    logic            sat;
  } div_item_t;

  function automatic norm_t normalize(input logic [NORM_W-1:0] x);
    norm_t r;
    r.k = '0;
    for (int i = 0; i < NORM_W; i++) begin
      if (x[i]) begin
        r.k = KW'(i);
      end
    end
    r.mant = MANT_W'(x) << (MANT_W - 1 - int'(r.k));
    return r;
  endfunction

  function automatic sq_t square_step(input logic [MANT_W-1:0] m);
    logic [PROD_W-1:0] p;
    sq_t r;
    p = PROD_W'(m) * PROD_W'(m);
    r.hit = p[PROD_W-1];
    r.mant = r.hit ? p[PROD_W-1:MANT_W] : p[PROD_W-2:MANT_W-1];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/rpb_cfg.sv =====
// rpb_cfg: configuration registers and a sequencer that derives the log2
// terms of the bucket mapping with one shared squaring unit. Uses rpb_pkg.
`default_nettype none

module rpb_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [rpb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rpb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rpb_pkg::cfg_t                         cfg,
  output logic                                  busy
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [ST_W-1:0] ST_FAR_NORM = 3'd1;
  localparam logic [ST_W-1:0] ST_FAR_SQ   = 3'd2;
  localparam logic [ST_W-1:0] ST_EX_NORM  = 3'd3;
  localparam logic [ST_W-1:0] ST_EX_SQ    = 3'd4;
  localparam logic [ST_W-1:0] ST_FINISH   = 3'd5;

  localparam logic [rpb_pkg::CNT_W-1:0] CNT_LAST =
    rpb_pkg::CNT_W'(rpb_pkg::LOG_FRAC_BITS - 1);

  logic [rpb_pkg::BC_W-1:0]     bucket_count;
  logic [rpb_pkg::FAR_W-1:0]    far_distance;
  logic [ST_W-1:0]              state;
  logic [rpb_pkg::CNT_W-1:0]    count;
  logic [rpb_pkg::MANT_W-1:0]   mant;
  logic [rpb_pkg::LOG_W-1:0]    acc;
  logic [rpb_pkg::LOG_W-1:0]    l_far;
  rpb_pkg::cfg_t                cur;

  logic [rpb_pkg::BC_W-1:0]     bc_clamped;
  logic [rpb_pkg::HALF_W-1:0]   half_w;
  logic [rpb_pkg::EXACT_W-1:0]  exact_w;
  logic [rpb_pkg::NORM_W-1:0]   norm_src;
  rpb_pkg::norm_t               nrm;
  rpb_pkg::sq_t                 sq;
  logic [rpb_pkg::LOG_W-1:0]    acc_next;

  always_comb begin
    bc_clamped = (bucket_count > rpb_pkg::BC_MAX) ? rpb_pkg::BC_MAX : bucket_count;
    half_w     = bc_clamped[rpb_pkg::BC_W-1:1];
    exact_w    = half_w[rpb_pkg::HALF_W-1:1];
    norm_src   = (state == ST_FAR_NORM) ? rpb_pkg::NORM_W'(far_distance)
                                        : rpb_pkg::NORM_W'(exact_w);
    nrm        = rpb_pkg::normalize(norm_src);
    sq         = rpb_pkg::square_step(mant);
    acc_next   = {acc[rpb_pkg::LOG_W-2:0], sq.hit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= rpb_pkg::BC_RESET;
      far_distance <= rpb_pkg::FAR_RESET;
      state        <= ST_FAR_NORM;
      count        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rpb_pkg::REG_BUCKET_COUNT: bucket_count <= cfg_data[rpb_pkg::BC_W-1:0];
        rpb_pkg::REG_FAR_DISTANCE: far_distance <= cfg_data[rpb_pkg::FAR_W-1:0];
        default: ;
      endcase
      state <= ST_FAR_NORM;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: ;
        ST_FAR_NORM: begin
          state <= ST_FAR_SQ;
          count <= '0;
        end
        ST_FAR_SQ: begin
          count <= count + 1'b1;
          if (count == CNT_LAST) begin
            state <= ST_EX_NORM;
          end
        end
        ST_EX_NORM: begin
          state <= ST_EX_SQ;
          count <= '0;
        end
        ST_EX_SQ: begin
          count <= count + 1'b1;
          if (count == CNT_LAST) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_FAR_NORM, ST_EX_NORM: begin
        mant <= nrm.mant;
        acc  <= rpb_pkg::LOG_W'(nrm.k);
      end
      ST_FAR_SQ: begin
        mant <= sq.mant;
        acc  <= acc_next;
        if (count == CNT_LAST) begin
          l_far <= acc_next;
        end
      end
      ST_EX_SQ: begin
        mant <= sq.mant;
        acc  <= acc_next;
        if (count == CNT_LAST) begin
          cur.l_exact <= acc_next;
        end
      end
      ST_FINISH: begin
        cur.half  <= half_w;
        cur.exact <= exact_w;
        cur.span  <= rpb_pkg::EXACT_W'(half_w - rpb_pkg::HALF_W'(exact_w));
        cur.den   <= l_far - cur.l_exact;
        cur.degen <= (l_far <= cur.l_exact);
      end
      default: ;
    endcase
  end

  assign cfg  = cur;
  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/rpb_front.sv =====
// rpb_front: two pipeline stages, magnitude and sign of the offset, then
// bucket classification and mantissa normalization. Uses rpb_pkg.
`default_nettype none

module rpb_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rpb_pkg::cfg_t                  cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rpb_pkg::POS_BITS-1:0]   rel_pos,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rpb_pkg::log_item_t                  out_item
);

  typedef struct packed {
    logic                         pos;
    logic [rpb_pkg::POS_BITS-1:0] magnitude;
  } abs_t;

  logic                 va;
  logic                 vb;
  abs_t                 a;
  rpb_pkg::log_item_t   b;
  logic                 ra;
  logic                 rb;
  abs_t                 a_next;
  rpb_pkg::log_item_t   b_next;
  rpb_pkg::norm_t       nrm;
  logic [rpb_pkg::BUCKET_W-1:0] base;
  logic                 neg;

  always_comb begin
    rb = !vb || out_ready;
    ra = !va || rb;

    neg              = rel_pos[rpb_pkg::POS_BITS-1];
    a_next.magnitude = neg ? (~rel_pos + 1'b1) : rel_pos;
    a_next.pos       = !neg && (rel_pos != '0);

    nrm  = rpb_pkg::normalize(rpb_pkg::NORM_W'(a.magnitude));
    base = a.pos ? rpb_pkg::BUCKET_W'(cfg.half) : '0;
    b_next.mant       = nrm.mant;
    b_next.acc        = rpb_pkg::LOG_W'(nrm.k);
    b_next.tag.direct = 1'b1;
    b_next.tag.bucket = base;
    if (cfg.half == '0) begin
      b_next.tag.bucket = '0;
    end else if (a.magnitude < rpb_pkg::POS_BITS'(cfg.exact)) begin
      b_next.tag.bucket = base + rpb_pkg::BUCKET_W'(a.magnitude);
    end else if (cfg.exact == '0 || cfg.degen) begin
      b_next.tag.bucket = base + rpb_pkg::BUCKET_W'(cfg.half) - 1'b1;
    end else begin
      b_next.tag.direct = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ra) begin
        va <= in_valid;
      end
      if (rb) begin
        vb <= va;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ra) begin
      a <= a_next;
    end
    if (rb) begin
      b <= b_next;
    end
  end

  assign in_ready  = ra;
  assign out_valid = vb;
  assign out_item  = b;

endmodule

`default_nettype wire

// ===== design/rpb_log.sv =====
// rpb_log: fractional log2 bits by repeated squaring, one squaring per
// pipeline stage. Uses rpb_pkg.
`default_nettype none

module rpb_log (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rpb_pkg::log_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rpb_pkg::log_item_t      out_item
);

  localparam int NS = rpb_pkg::LOG_FRAC_BITS;

  logic               v   [NS];
  logic               vin [NS];
  logic               rdy [NS];
  rpb_pkg::log_item_t d   [NS];
  rpb_pkg::log_item_t src [NS];
  rpb_pkg::log_item_t nxt [NS];
  rpb_pkg::sq_t       sq  [NS];

  always_comb begin
    src[0] = in_item;
    vin[0] = in_valid;
    for (int i = 1; i < NS; i++) begin
      src[i] = d[i-1];
      vin[i] = v[i-1];
    end
    rdy[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
    for (int i = 0; i < NS; i++) begin
      sq[i]       = rpb_pkg::square_step(src[i].mant);
      nxt[i].tag  = src[i].tag;
      nxt[i].mant = sq[i].mant;
      nxt[i].acc  = {src[i].acc[rpb_pkg::LOG_W-2:0], sq[i].hit};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= vin[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (rdy[i]) begin
        d[i] <= nxt[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];
  assign out_item  = d[NS-1];

endmodule

`default_nettype wire

// ===== design/rpb_div.sv =====
// rpb_div: log difference, scale, pipelined restoring divide with
// saturation, and final bucket clamp into the output register. Uses rpb_pkg.
`default_nettype none

module rpb_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rpb_pkg::cfg_t                  cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rpb_pkg::log_item_t             in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rpb_pkg::BUCKET_W-1:0]        bucket
);

  localparam int NS = rpb_pkg::DIV_STAGES;

  logic                          v   [NS];
  logic                          vin [NS];
  logic                          rdy [NS];
  rpb_pkg::div_item_t            d   [NS];
  rpb_pkg::div_item_t            nxt [NS];
  logic [rpb_pkg::DV_W-1:0]      shifted;
  logic [rpb_pkg::HALF_W-1:0]    sum;
  logic [rpb_pkg::HALF_W-1:0]    lim;
  logic [rpb_pkg::HALF_W-1:0]    scaled;

  always_comb begin
    shifted = '0;
    sum     = '0;
    lim     = '0;
    scaled  = '0;
    vin[0]  = in_valid;
    for (int i = 1; i < NS; i++) begin
      vin[i] = v[i-1];
    end
    rdy[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
    for (int i = 0; i < NS; i++) begin
      if (i == 0) begin
        nxt[i].tag = in_item.tag;
        nxt[i].val = rpb_pkg::DV_W'(in_item.acc - cfg.l_exact);
        nxt[i].q   = '0;
        nxt[i].sat = 1'b0;
      end else begin
        nxt[i] = d[i-1];
        if (i == 1) begin
          nxt[i].val = rpb_pkg::DV_W'(d[i-1].val[rpb_pkg::LOG_W-1:0])
                     * rpb_pkg::DV_W'(cfg.span);
        end else if (i == 2) begin
          nxt[i].sat = (d[i-1].val >= {cfg.den, rpb_pkg::QW'(0)});
        end else if (i < NS - 1) begin
          shifted = rpb_pkg::DV_W'(cfg.den) << (rpb_pkg::QW - 1 - (i - 3));
          if (!d[i-1].sat && d[i-1].val >= shifted) begin
            nxt[i].val = d[i-1].val - shifted;
            nxt[i].q[rpb_pkg::QW-1-(i-3)] = 1'b1;
          end
        end else begin
          sum    = rpb_pkg::HALF_W'(d[i-1].q) + rpb_pkg::HALF_W'(cfg.exact);
          lim    = cfg.half - 1'b1;
          scaled = (d[i-1].sat || sum > lim) ? lim : sum;
          if (!d[i-1].tag.direct) begin
            nxt[i].tag.direct = 1'b1;
            nxt[i].tag.bucket = d[i-1].tag.bucket + rpb_pkg::BUCKET_W'(scaled);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= vin[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (rdy[i]) begin
        d[i] <= nxt[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];
  assign bucket    = d[NS-1].tag.bucket;

endmodule

`default_nettype wire

// ===== design/relative_position_bucket.sv =====
// relative_position_bucket: signed offset to bidirectional attention bucket.
// One transaction per cycle while out_ready is high and the block is not busy,
// set by one squaring multiplier per log2 stage and one compare-subtract per
// quotient bit. Reset is synchronous; after reset and after any register write,
// in_ready stays low while the shared squaring unit derives log2(far_distance)
// and log2(exact limit).
`default_nettype none

module relative_position_bucket (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [rpb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rpb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [rpb_pkg::POS_BITS-1:0] rel_pos,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [rpb_pkg::BUCKET_W-1:0]          bucket
);

  rpb_pkg::cfg_t      cfg;
  logic               busy;
  logic               front_ready;
  logic               front_valid;
  rpb_pkg::log_item_t front_item;
  logic               log_ready;
  logic               log_valid;
  rpb_pkg::log_item_t log_item;
  logic               div_ready;

  rpb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .busy      (busy)
  );

  rpb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid && !busy),
    .in_ready  (front_ready),
    .rel_pos   (rel_pos),
    .out_valid (front_valid),
    .out_ready (log_ready),
    .out_item  (front_item)
  );

  rpb_log u_log (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (log_ready),
    .in_item   (front_item),
    .out_valid (log_valid),
    .out_ready (div_ready),
    .out_item  (log_item)
  );

  rpb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (log_valid),
    .in_ready  (div_ready),
    .in_item   (log_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bucket    (bucket)
  );

  assign in_ready = front_ready && !busy;

endmodule

`default_nettype wire

// ===== tb/sv/relative_position_bucket_test.sv =====
// Self-checking testbench for relative_position_bucket: drives signed offsets under
// several bucket_count / far_distance settings and checks each bucket index against
// a fixed-point predictor. Depends on rpb_pkg and the relative_position_bucket RTL.
`timescale 1ns / 1ps

module relative_position_bucket_test;

  logic                                  clk;
  logic                                  rst;
  logic                                  cfg_write;
  logic [rpb_pkg::CFG_IDX_W-1:0]         cfg_index;
  logic [rpb_pkg::CFG_DATA_W-1:0]        cfg_data;
  logic                                  in_valid;
  logic                                  in_ready;
  logic signed [rpb_pkg::POS_BITS-1:0]   rel_pos;
  logic                                  out_valid;
  logic                                  out_ready;
  logic [rpb_pkg::BUCKET_W-1:0]          bucket;

  logic [rpb_pkg::BC_W-1:0]              model_count;
  logic [rpb_pkg::FAR_W-1:0]             model_far;
  logic [rpb_pkg::BUCKET_W-1:0]          pending_buckets[$];
  bit                                    idle_on;
  int                                    fails;
  int                                    sent_positions;
  int                                    checked_buckets;
  int                                    reg_writes;
  int                                    stall_left;

  relative_position_bucket dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rel_pos   (rel_pos),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bucket    (bucket)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint unsigned log2_fixed(input longint unsigned x);
    longint unsigned m;
    longint unsigned acc;
    int              k;
    if (x == 0) return 0;
    k = 0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) k = i;
    end
    m = (k <= 31) ? (x << (31 - k)) : (x >> (k - 31));
    acc = longint'(k);
    for (int i = 0; i < rpb_pkg::LOG_FRAC_BITS; i++) begin
      m = (m * m) >> 31;
      acc = acc << 1;
      if (m >= 64'h1_0000_0000) begin
        acc |= 1;
        m >>= 1;
      end
    end
    return acc;
  endfunction

  function automatic logic [rpb_pkg::BUCKET_W-1:0] bucket_of(
      input logic [rpb_pkg::POS_BITS-1:0] pos,
      input logic [rpb_pkg::BC_W-1:0]     count,
      input logic [rpb_pkg::FAR_W-1:0]    far);
    longint unsigned magnitude, bc, half, exact, base, log_bucket;
    longint unsigned l_exact, l_far, num, den;
    bit              ahead;
    magnitude = pos[rpb_pkg::POS_BITS-1] ? ((longint'(1) << rpb_pkg::POS_BITS) - pos) : pos;
    ahead = !pos[rpb_pkg::POS_BITS-1] && pos != 0;
    bc = (count > rpb_pkg::BC_MAX) ? rpb_pkg::BC_MAX : count;
    half = bc / 2;
    exact = half / 2;
    if (half == 0) return '0;
    base = ahead ? half : 0;
    if (magnitude < exact) return rpb_pkg::BUCKET_W'(base + magnitude);
    if (exact == 0) begin
      log_bucket = half - 1;
    end else begin
      l_exact = log2_fixed(exact);
      l_far = log2_fixed(far);
      if (l_far <= l_exact) begin
        log_bucket = half - 1;
      end else begin
        num = log2_fixed(magnitude) - l_exact;
        den = l_far - l_exact;
        log_bucket = exact + (num * (half - exact)) / den;
        if (log_bucket > half - 1) log_bucket = half - 1;
      end
    end
    return rpb_pkg::BUCKET_W'(base + log_bucket);
  endfunction

  function automatic logic [rpb_pkg::POS_BITS-1:0] pick_position();
    int unsigned mag;
    case ($urandom_range(0, 3))
      0: return rpb_pkg::POS_BITS'($urandom);
      1: mag = $urandom_range(0, 200);
      2: begin
        mag = int'(model_far) + $urandom_range(0, 8);
        mag = (mag < 4) ? 0 : mag - 4;
        if (mag > 32768) mag = 32768;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: mag = 0;
          1: mag = 1;
          2: mag = 32767;
          default: mag = 32768;
        endcase
      end
    endcase
    return $urandom_range(0, 1) ? rpb_pkg::POS_BITS'(0 - mag) : rpb_pkg::POS_BITS'(mag);
  endfunction

  // One output transaction per handshake; stall in short bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_buckets.size() == 0) begin
        $error("bucket: unexpected transaction, actual %0d", bucket);
        fails++;
      end else begin
        if (bucket !== pending_buckets[0]) begin
          $error("bucket: expected %0d, actual %0d", pending_buckets[0], bucket);
          fails++;
        end
        void'(pending_buckets.pop_front());
        checked_buckets++;
      end
    end
  end

  task automatic send_position(input logic [rpb_pkg::POS_BITS-1:0] pos);
    in_valid <= 1'b1;
    rel_pos <= pos;
    do @(posedge clk); while (!in_ready);
    pending_buckets.push_back(bucket_of(pos, model_count, model_far));
    sent_positions++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_buckets.size() != 0);
  endtask

  // Hold the write enable; the caller drops it after its last write.
  task automatic write_reg(input logic [rpb_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [rpb_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == rpb_pkg::REG_BUCKET_COUNT) model_count = data[rpb_pkg::BC_W-1:0];
    else model_far = data;
    reg_writes++;
  endtask

  // Upper data bits above the count field are don't-care; toggle them anyway.
  task automatic apply_setting(input int unsigned count, input int unsigned far);
    drain();
    write_reg(rpb_pkg::REG_BUCKET_COUNT,
              {rpb_pkg::CFG_DATA_W'($urandom) & ~rpb_pkg::CFG_DATA_W'(16'h1FF)}
              | rpb_pkg::CFG_DATA_W'(count));
    write_reg(rpb_pkg::REG_FAR_DISTANCE, rpb_pkg::CFG_DATA_W'(far));
    cfg_write <= 1'b0;
  endtask

  task automatic run_positions(input int n);
    for (int i = 0; i < n; i++) begin
      send_position(pick_position());
    end
  endtask

  task automatic test_directed();
    logic [rpb_pkg::POS_BITS-1:0] picks[$];
    picks = '{16'd0, 16'd1, 16'hFFFF, 16'd7, 16'd8, 16'hFFF8, 16'd15, 16'd16,
              16'hFFF0, 16'd100, 16'd127, 16'd128, 16'hFF80, 16'd129, 16'h7FFF,
              16'h8000, 16'h5555, 16'hAAAA};
    idle_on = 1'b1;
    foreach (picks[i]) send_position(picks[i]);
    apply_setting(511, 65535);
    send_position(16'h8000);
    send_position(16'h7FFF);
    send_position(16'd63);
    send_position(16'd64);
  endtask

  task automatic test_corner_settings();
    int unsigned counts[$];
    int unsigned fars[$];
    counts = '{0, 1, 2, 3, 4, 4, 5, 6, 8, 64, 255, 256, 256, 256, 256, 257, 511};
    fars   = '{128, 128, 128, 100, 2, 65535, 3, 1, 2, 16, 0, 64, 63, 65, 65535, 200, 65535};
    foreach (counts[i]) begin
      idle_on = (i % 3) != 2;
      apply_setting(counts[i], fars[i]);
      run_positions(30);
    end
  endtask

  task automatic test_random_settings();
    int unsigned count, far;
    for (int p = 0; p < 16; p++) begin
      count = $urandom_range(0, 1) ? $urandom_range(4, 256) : $urandom_range(0, 511);
      case ($urandom_range(0, 2))
        0: far = $urandom_range(0, 65535);
        1: far = $urandom_range(0, 400);
        default: far = (count / 4) + $urandom_range(0, 3);
      endcase
      idle_on = $urandom_range(0, 3) != 0;
      apply_setting(count, far);
      run_positions(40);
    end
  endtask

  task automatic test_full_rate();
    apply_setting(256, $urandom_range(65, 65535));
    idle_on = 1'b0;
    run_positions(150);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    rel_pos = '0;
    out_ready = 1'b0;
    idle_on = 1'b0;
    stall_left = 0;
    fails = 0;
    sent_positions = 0;
    checked_buckets = 0;
    reg_writes = 0;
    model_count = rpb_pkg::BC_RESET;
    model_far = rpb_pkg::FAR_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_corner_settings();
    test_random_settings();
    test_full_rate();
    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d offsets across %0d register writes; compared %0d buckets.",
             sent_positions, reg_writes, checked_buckets);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
